FILE: rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg: shared types and constants of the ordered list table
// Holds the table depth, the request and response words, the operation and
// status codes, and the control word that steers each storage cell.
// ----------------------------------------------------------------------------
package olt_pkg;

   // Table size, the widths that follow from it, and the response count width.
   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int PASS_W  = $clog2(DEPTH);
   localparam int COUNT_W = 5;

   // Operation codes carried in the mode field.
   localparam logic [2:0] MODE_HEAD_INS = 3'd0;
   localparam logic [2:0] MODE_END_INS  = 3'd1;
   localparam logic [2:0] MODE_POS_INS  = 3'd2;
   localparam logic [2:0] MODE_VAL_DEL  = 3'd3;
   localparam logic [2:0] MODE_POS_DEL  = 3'd4;
   localparam logic [2:0] MODE_SORT     = 3'd5;
   localparam logic [2:0] MODE_LIST     = 3'd6;

   // Status codes returned with every response word.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] value;
      logic [7:0]         position;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         count;
      logic signed [31:0] item_value;
      logic               item_valid;
      logic               last;
   } rsp_word_type;

   // Where a cell takes its next value from.
   typedef enum logic [1:0] {
      SEL_HOLD,
      SEL_NEW,
      SEL_LEFT,
      SEL_RIGHT
   } cell_sel_type;

   typedef struct packed {
      cell_sel_type sel;
      logic         in_range;
   } cell_ctl_type;

endpackage

FILE: rtl/olt_cell.sv
// ----------------------------------------------------------------------------
// olt_cell: one storage cell of the ordered list table
// Holds one entry, loads it from a neighbor or from the shared new value,
// forwards the match chain and reports the order against its right neighbor.
// ----------------------------------------------------------------------------
module olt_cell (
   input  logic                 clock,
   input  olt_pkg::cell_ctl_type ctl,
   input  logic signed [31:0]   new_value,
   input  logic signed [31:0]   left_value,
   input  logic signed [31:0]   right_value,
   input  logic signed [31:0]   key_value,
   input  logic                 seen_in,
   output logic signed [31:0]   value,
   output logic                 seen_out,
   output logic                 greater
);
   import olt_pkg::*;

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   // Select the next entry value.
   always_comb begin
      unique case (ctl.sel)
         SEL_NEW:   value_in = new_value;
         SEL_LEFT:  value_in = left_value;
         SEL_RIGHT: value_in = right_value;
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // A match at or before this cell makes this cell close the gap.
   assign seen_out = seen_in | (ctl.in_range && (value_ff == key_value));
   assign greater  = value_ff > right_value;
   assign value    = value_ff;

endmodule

FILE: rtl/ordered_list_table_core.sv
// Inserts, position deletes and unknown modes pass from idle to the post state, which
// loads the response; value delete removes matches one by one and sort runs DEPTH passes first.
// List sends one word per entry, one per cycle when the response side does not stall.
// One operation is in flight at a time; the next word is accepted once it completes.
// Reset clears the entry count and the control state; the cell contents are not cleared.
// ----------------------------------------------------------------------------
// ordered_list_table_core: ordered table of signed entries in a chain of cells
// Each cell holds one entry and shifts to a neighbor for inserts and deletes,
// swaps in odd-even passes for sorting, and rotates toward the output to list.
// ----------------------------------------------------------------------------
module ordered_list_table_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  olt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output olt_pkg::rsp_word_type rsp_word
);
   import olt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEL,
      S_SORT,
      S_LIST,
      S_POST
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [PASS_W-1:0]  pass_ff;
   logic [CNT_W-1:0]   list_idx_ff;
   logic [1:0]         status_ff;
   logic signed [31:0] key_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;

   cell_ctl_type       ctl [DEPTH];
   logic signed [31:0] cell_value [DEPTH];
   logic               seen [DEPTH+1];
   logic               greater [DEPTH];
   logic               swap_pair [DEPTH];
   logic signed [31:0] new_value;

   logic               accept;
   logic               out_free;
   logic               rsp_load;
   logic               full;
   logic               do_ins;
   logic               do_del;
   logic [CNT_W-1:0]   op_idx;
   logic [1:0]         dec_status;
   logic [8:0]         pos9;
   logic [8:0]         cnt9;
   logic               list_last;

   assign accept    = (state_ff == S_IDLE) && req_valid;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = out_free && ((state_ff == S_LIST) || (state_ff == S_POST));
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pos9      = {1'b0, req_word.position};
   assign cnt9      = 9'(count_ff);
   assign list_last = ((list_idx_ff + 1'b1) == count_ff);

   // Decode the request word into a shift operation and a status.
   always_comb begin
      do_ins     = 1'b0;
      do_del     = 1'b0;
      op_idx     = '0;
      dec_status = ST_OK;
      unique case (req_word.mode)
         MODE_HEAD_INS: begin
            if (full) dec_status = ST_FULL;
            else      do_ins     = accept;
         end
         MODE_END_INS: begin
            op_idx = count_ff;
            if (full) dec_status = ST_FULL;
            else      do_ins     = accept;
         end
         MODE_POS_INS: begin
            op_idx = CNT_W'(pos9 - 9'd1);
            if (pos9 == 9'd0 || pos9 > cnt9 + 9'd1) dec_status = ST_INVALID;
            else if (full)                          dec_status = ST_FULL;
            else                                    do_ins     = accept;
         end
         MODE_POS_DEL: begin
            op_idx = CNT_W'(pos9 - 9'd1);
            if (pos9 == 9'd0 || pos9 > cnt9) dec_status = ST_INVALID;
            else                             do_del     = accept;
         end
         default: begin
            dec_status = ST_OK;
         end
      endcase
   end

   // Odd-even exchange: pair (i, i+1) swaps on its phase when out of order.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         swap_pair[i] = (i < DEPTH - 1) && (state_ff == S_SORT) &&
                        (1'(i) == pass_ff[0]) &&
                        (CNT_W'(i + 1) < count_ff) && greater[i];
      end
   end

   // Per-cell steering.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ctl[i].in_range = CNT_W'(i) < count_ff;
         ctl[i].sel      = SEL_HOLD;
         if (do_ins) begin
            if (CNT_W'(i) > op_idx)       ctl[i].sel = SEL_LEFT;
            else if (CNT_W'(i) == op_idx) ctl[i].sel = SEL_NEW;
         end else if (do_del) begin
            if (CNT_W'(i) >= op_idx) ctl[i].sel = SEL_RIGHT;
         end else if (state_ff == S_DEL) begin
            if (seen[i+1]) ctl[i].sel = SEL_RIGHT;
         end else if (state_ff == S_SORT) begin
            if (swap_pair[i]) ctl[i].sel = SEL_RIGHT;
            else if (i > 0 && swap_pair[(i > 0) ? i - 1 : 0]) ctl[i].sel = SEL_LEFT;
         end else if (state_ff == S_LIST && out_free) begin
            if (CNT_W'(i + 1) < count_ff)       ctl[i].sel = SEL_RIGHT;
            else if (CNT_W'(i + 1) == count_ff) ctl[i].sel = SEL_NEW;
         end
      end
   end

   // The front entry wraps to the back while listing.
   assign new_value = (state_ff == S_LIST) ? cell_value[0] : req_word.value;
   assign seen[0]   = 1'b0;

   // The chain of cells.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      olt_cell u_cell (
         .clock       (clock),
         .ctl         (ctl[g]),
         .new_value   (new_value),
         .left_value  ((g == 0) ? 32'sd0 : cell_value[(g == 0) ? 0 : g - 1]),
         .right_value ((g == DEPTH - 1) ? 32'sd0
                                        : cell_value[(g == DEPTH - 1) ? g : g + 1]),
         .key_value   (key_ff),
         .seen_in     (seen[g]),
         .value       (cell_value[g]),
         .seen_out    (seen[g+1]),
         .greater     (greater[g])
      );
   end

   // Sequencer, entry count and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new word is loaded, or a taken word leaves the register.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  status_ff <= dec_status;
                  key_ff    <= req_word.value;
                  pass_ff   <= '0;
                  list_idx_ff <= '0;
                  if (do_ins) count_ff <= count_ff + 1'b1;
                  if (do_del) count_ff <= count_ff - 1'b1;
                  if (req_word.mode == MODE_VAL_DEL) begin
                     state_ff <= S_DEL;
                  end else if (req_word.mode == MODE_SORT) begin
                     state_ff <= S_SORT;
                  end else if (req_word.mode == MODE_LIST && count_ff != '0) begin
                     state_ff <= S_LIST;
                  end else begin
                     state_ff <= S_POST;
                  end
               end
            end
            S_DEL: begin
               // One matching entry leaves per cycle until none is left.
               if (seen[DEPTH]) count_ff <= count_ff - 1'b1;
               else             state_ff <= S_POST;
            end
            S_SORT: begin
               pass_ff <= pass_ff + 1'b1;
               if (pass_ff == PASS_W'(DEPTH - 1)) state_ff <= S_POST;
            end
            S_LIST: begin
               if (out_free) begin
                  rsp_word_ff.status     <= ST_OK;
                  rsp_word_ff.count      <= COUNT_W'(count_ff);
                  rsp_word_ff.item_value <= cell_value[0];
                  rsp_word_ff.item_valid <= 1'b1;
                  rsp_word_ff.last       <= list_last;
                  list_idx_ff            <= list_idx_ff + 1'b1;
                  if (list_last) state_ff <= S_IDLE;
               end
            end
            S_POST: begin
               if (out_free) begin
                  rsp_word_ff.status     <= status_ff;
                  rsp_word_ff.count      <= COUNT_W'(count_ff);
                  rsp_word_ff.item_value <= '0;
                  rsp_word_ff.item_valid <= 1'b0;
                  rsp_word_ff.last       <= 1'b1;
                  state_ff               <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: rtl/olt_checker.sv
// ----------------------------------------------------------------------------
// olt_checker: port-level checks of the ordered list table
// Watches the request channel for one operation at a time and the response
// channel for a held word and for consistent fields.
// ----------------------------------------------------------------------------
module olt_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input olt_pkg::rsp_word_type rsp_word
);
   import olt_pkg::*;

   // A stalled response word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // The count never exceeds the table depth.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.count <= COUNT_W'(DEPTH))
      else $error("response count above depth");

   // Once a request word is taken, the next one waits.
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an operation is in flight");

   // Words without an item carry a zero item value and are marked last.
   a_item_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.item_valid |-> rsp_word.item_value == '0 && rsp_word.last)
      else $error("empty word with item value or without last");

   // A full status is only reported by a full table.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_FULL |-> rsp_word.count == COUNT_W'(DEPTH))
      else $error("full status with room left");

endmodule

bind ordered_list_table_core olt_checker u_olt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
